/* sv/odo_pkg.sv */
// odo_pkg: shared types and constants of the trapezoid odometer integrator
// payload structs, operation, outcome and register codes, multiplier widths
// no dependencies
package odo_pkg;

  // operation codes
  localparam logic [1:0] OP_SAMPLE     = 2'd0;
  localparam logic [1:0] OP_CLEAR_TRIP = 2'd1;
  localparam logic [1:0] OP_LOAD       = 2'd2;

  // outcome codes
  localparam logic [2:0] OC_ACCEPTED  = 3'd0;
  localparam logic [2:0] OC_FIRST     = 3'd1;
  localparam logic [2:0] OC_BAD_RPM   = 3'd2;
  localparam logic [2:0] OC_DUPLICATE = 3'd3;
  localparam logic [2:0] OC_GAP       = 3'd4;
  localparam logic [2:0] OC_TRIP_CLR  = 3'd5;
  localparam logic [2:0] OC_LOADED    = 3'd6;
  localparam logic [2:0] OC_UNCAL     = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_FACTOR  = 2'd0;
  localparam logic [1:0] CFG_MAX_RPM = 2'd1;
  localparam logic [1:0] CFG_MAX_GAP = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // register reset values
  localparam logic [15:0] DEFAULT_MAX_RPM = 16'd12000;
  localparam logic [15:0] DEFAULT_MAX_GAP = 16'd10000;

  // mm per s from mm per ms
  localparam logic [16:0] SPEED_SCALE = 17'd1000;

  // shared multiplier: 49 x 17 bits covers factor x rpm sum and (factor x rpm sum) x dt
  localparam int MUL_A_W = 49;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] motor_rpm;
    logic [31:0] sample_time_ms;
    logic [47:0] load_total_mm;
    logic [47:0] load_trip_mm;
  } odo_in_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [47:0] total_mm;
    logic [47:0] trip_mm;
    logic [31:0] speed_mm_per_s;
    logic [31:0] accepted_count;
    logic [31:0] rejected_rpm_count;
    logic [31:0] gap_count;
    logic [15:0] previous_rpm;
  } odo_out_t;

endpackage

/* sv/trapezoid_odometer_integrator.sv */
// trapezoid_odometer_integrator: top level, sequencer, state and result register
// depends on odo_pkg and odo_mul
//
// usage
//   in_valid/in_ready carry one item: a speed sample, a trip clear or a load of
//   stored totals. every item gives exactly one result on out_valid/out_ready
//   with the outcome code and all distances, speed and counters after the item.
//   cfg_we/cfg_index/cfg_wdata write a register, with no read-back.
// sequencing
//   trip clear, load, unknown operations and rejected samples go straight to the output step.
//   first, duplicate and gap samples pass the speed estimate steps only.
//   integrated samples also pass the integration steps. the single 49 x 17
//   multiplier is used four times per sample, and the remainder add and
//   saturating add follow it. in_ready is high only while the sequencer is
//   idle, so one item is in work at a time; a result waiting in the output
//   register does not hold off the next item until that item is done.
// reset
//   synchronous, active low: all distances, counters and the reference are
//   cleared, factor 0 (uncalibrated), rpm limit 12000, gap limit 10000 ms.
// stall
//   while out_ready is low the result holds; a finished item waits in the
//   output stage until the register is free.
module trapezoid_odometer_integrator #(
  parameter int FRACTION_BITS = 32,
  parameter int DISTANCE_BITS = 48,
  parameter int TIME_BITS     = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  odo_pkg::odo_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output odo_pkg::odo_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [odo_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [odo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import odo_pkg::*;

  // sum of half the product and the remainder, and its whole-mm part
  localparam int SUM_W   = MUL_P_W - 1;
  localparam int WHOLE_W = SUM_W - FRACTION_BITS;
  localparam int SAT_W   = ((DISTANCE_BITS > WHOLE_W) ? DISTANCE_BITS : WHOLE_W) + 1;
  localparam logic [DISTANCE_BITS-1:0] DIST_MAX = {DISTANCE_BITS{1'b1}};
  localparam logic [SAT_W-1:0] DIST_MAX_EXT = {{(SAT_W - DISTANCE_BITS){1'b0}}, DIST_MAX};

  typedef enum logic [2:0] {
    S_IDLE,  // waiting for an item
    S_SPD1,  // factor x rpm
    S_SPD2,  // (factor x rpm) x 1000
    S_SPD3,  // speed captured, factor x rpm sum
    S_INT,   // (factor x rpm sum) x dt
    S_ACC,   // halve, add remainder, split whole mm
    S_SAT,   // saturating add into total and trip
    S_OUT    // load result register
  } state_t;

  state_t state_r;

  // configuration
  logic [31:0]              factor_r;
  logic [15:0]              max_rpm_r;
  logic [15:0]              max_gap_r;

  // architectural state
  logic [FRACTION_BITS-1:0] rem_r;
  logic [DISTANCE_BITS-1:0] total_r;
  logic [DISTANCE_BITS-1:0] trip_r;
  logic [15:0]              ref_rpm_r;
  logic [TIME_BITS-1:0]     ref_time_r;
  logic                     ref_valid_r;
  logic [31:0]              speed_r;
  logic [31:0]              accepted_ctr_r;
  logic [31:0]              bad_rpm_ctr_r;
  logic [31:0]              gap_ctr_r;

  // item in work
  logic [15:0]              rpm_r;
  logic [16:0]              rpm_sum_r;
  logic [15:0]              dt_r;
  logic [2:0]               outcome_r;
  logic                     integ_r;
  logic [WHOLE_W-1:0]       whole_r;

  // result register
  logic                     out_valid_r;
  odo_out_t                 out_data_r;
  logic                     out_load;

  // shared multiplier
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [MUL_P_W-1:0]       prod_r;

  // decode of the incoming item
  logic [15:0]              rpm_limit;
  logic [TIME_BITS-1:0]     t_cur;
  logic [TIME_BITS-1:0]     dt_cur;
  logic                     uncal;
  logic                     in_xfer;
  logic                     spd_go;

  // integration helpers
  logic [SUM_W-1:0]         acc_sum;
  logic [SAT_W-1:0]         total_sum;
  logic [SAT_W-1:0]         trip_sum;
  logic [MUL_P_W-1:0]       spd_shift;
  logic [63:0]              total_ext;
  logic [63:0]              trip_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // result register takes the finished item once it is empty or being read
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // zero rpm limit register falls back to the default
  assign rpm_limit = (max_rpm_r == 16'd0) ? DEFAULT_MAX_RPM : max_rpm_r;
  assign t_cur     = in_data.sample_time_ms[TIME_BITS-1:0];
  assign dt_cur    = t_cur - ref_time_r;
  assign uncal     = (factor_r == 32'd0);

  // calibrated plausible sample: goes through the speed steps
  assign spd_go    = (in_data.operation == OP_SAMPLE) && !uncal &&
                     (in_data.motor_rpm <= rpm_limit);

  // trapezoid: half of the product plus the carried fraction
  assign acc_sum   = SUM_W'(prod_r[SUM_W-1:1]) + SUM_W'(rem_r);
  assign total_sum = SAT_W'(total_r) + SAT_W'(whole_r);
  assign trip_sum  = SAT_W'(trip_r) + SAT_W'(whole_r);
  assign spd_shift = prod_r >> FRACTION_BITS;
  assign total_ext = 64'(total_r);
  assign trip_ext  = 64'(trip_r);

  // multiplier operand selection per sequencer step
  always_comb begin
    case (state_r)
      S_SPD1: begin
        mul_a = MUL_A_W'(factor_r);
        mul_b = MUL_B_W'(rpm_r);
      end
      S_SPD2: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = SPEED_SCALE;
      end
      S_SPD3: begin
        mul_a = MUL_A_W'(factor_r);
        mul_b = rpm_sum_r;
      end
      S_INT: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(dt_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  odo_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      factor_r       <= '0;
      max_rpm_r      <= DEFAULT_MAX_RPM;
      max_gap_r      <= DEFAULT_MAX_GAP;
      rem_r          <= '0;
      total_r        <= '0;
      trip_r         <= '0;
      ref_rpm_r      <= '0;
      ref_time_r     <= '0;
      ref_valid_r    <= 1'b0;
      speed_r        <= '0;
      accepted_ctr_r <= '0;
      bad_rpm_ctr_r  <= '0;
      gap_ctr_r      <= '0;
      integ_r        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            rpm_r     <= in_data.motor_rpm;
            rpm_sum_r <= 17'(ref_rpm_r) + 17'(in_data.motor_rpm);
            dt_r      <= dt_cur[15:0];
            state_r   <= spd_go ? S_SPD1 : S_OUT;
            case (in_data.operation)
              OP_SAMPLE: begin
                if (uncal) begin
                  outcome_r <= OC_UNCAL;
                end else if (in_data.motor_rpm > rpm_limit) begin
                  // implausible: drop the reference, keep the time
                  bad_rpm_ctr_r <= bad_rpm_ctr_r + 32'd1;
                  ref_time_r    <= t_cur;
                  ref_valid_r   <= 1'b0;
                  outcome_r     <= OC_BAD_RPM;
                end else begin
                  // speed estimate follows for every plausible sample
                  ref_rpm_r <= in_data.motor_rpm;
                  if (!ref_valid_r) begin
                    ref_time_r  <= t_cur;
                    ref_valid_r <= 1'b1;
                    integ_r     <= 1'b0;
                    outcome_r   <= OC_FIRST;
                  end else if (dt_cur == '0) begin
                    integ_r   <= 1'b0;
                    outcome_r <= OC_DUPLICATE;
                  end else if (32'(dt_cur) > 32'(max_gap_r)) begin
                    gap_ctr_r  <= gap_ctr_r + 32'd1;
                    ref_time_r <= t_cur;
                    integ_r    <= 1'b0;
                    outcome_r  <= OC_GAP;
                  end else begin
                    ref_time_r <= t_cur;
                    integ_r    <= 1'b1;
                    outcome_r  <= OC_ACCEPTED;
                  end
                end
              end
              OP_CLEAR_TRIP: begin
                if (uncal) begin
                  outcome_r <= OC_UNCAL;
                end else begin
                  trip_r    <= '0;
                  outcome_r <= OC_TRIP_CLR;
                end
              end
              OP_LOAD: begin
                // loads regardless of calibration
                total_r   <= DISTANCE_BITS'(in_data.load_total_mm);
                trip_r    <= DISTANCE_BITS'(in_data.load_trip_mm);
                outcome_r <= OC_LOADED;
              end
              default: begin
                outcome_r <= OC_UNCAL;
              end
            endcase
          end
        end
        S_SPD1: begin
          state_r <= S_SPD2;
        end
        S_SPD2: begin
          state_r <= S_SPD3;
        end
        S_SPD3: begin
          speed_r <= spd_shift[31:0];
          state_r <= integ_r ? S_INT : S_OUT;
        end
        S_INT: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          rem_r   <= acc_sum[FRACTION_BITS-1:0];
          whole_r <= acc_sum[SUM_W-1:FRACTION_BITS];
          state_r <= S_SAT;
        end
        S_SAT: begin
          total_r        <= (total_sum > DIST_MAX_EXT) ? DIST_MAX
                                                       : total_sum[DISTANCE_BITS-1:0];
          trip_r         <= (trip_sum > DIST_MAX_EXT) ? DIST_MAX
                                                      : trip_sum[DISTANCE_BITS-1:0];
          accepted_ctr_r <= accepted_ctr_r + 32'd1;
          state_r        <= S_OUT;
        end
        S_OUT: begin
          // wait here only while an earlier result is still unread
          if (out_load) begin
            out_data_r.outcome            <= outcome_r;
            out_data_r.total_mm           <= total_ext[47:0];
            out_data_r.trip_mm            <= trip_ext[47:0];
            out_data_r.speed_mm_per_s     <= speed_r;
            out_data_r.accepted_count     <= accepted_ctr_r;
            out_data_r.rejected_rpm_count <= bad_rpm_ctr_r;
            out_data_r.gap_count          <= gap_ctr_r;
            out_data_r.previous_rpm       <= ref_rpm_r;
            state_r                       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // configuration writes are to arrive only while idle; the block does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          CFG_FACTOR: begin
            factor_r    <= cfg_wdata[31:0];
            rem_r       <= '0;
            ref_valid_r <= 1'b0;
          end
          CFG_MAX_RPM: begin
            max_rpm_r <= cfg_wdata[15:0];
          end
          CFG_MAX_GAP: begin
            max_gap_r <= cfg_wdata[15:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  // in_ready is low in the cycle after an accepted item
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_xfer |=> !in_ready)
    else $error("input taken again straight after a transfer");

  // a new result only ever comes from the output step
  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !out_valid_r |=> !out_valid_r || $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  // the integrated-sample counter moves exactly once per integration
  a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && state_r == S_SAT |=> accepted_ctr_r == $past(accepted_ctr_r) + 32'd1)
    else $error("accepted count not bumped on integration");

  // speed estimate is written only when the speed product is ready
  a_speed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && state_r != S_SPD3 |=> $stable(speed_r))
    else $error("speed estimate changed outside its step");
`endif

endmodule

/* sv/odo_mul.sv */
// odo_mul: shared unsigned multiplier with a registered product
// depends on odo_pkg for the operand widths
module odo_mul (
  input  logic                         clk,
  input  logic [odo_pkg::MUL_A_W-1:0]  mul_a,
  input  logic [odo_pkg::MUL_B_W-1:0]  mul_b,
  output logic [odo_pkg::MUL_P_W-1:0]  prod_r
);
  import odo_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

endmodule

/* sim/odo_result_checker.sv */
// odo_result_checker: watches the item, result and register ports of the odometer
// integrator, predicts every result and compares it field by field
// depends on odo_pkg
`timescale 1ns / 100ps

module odo_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  odo_pkg::odo_in_t                in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  odo_pkg::odo_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [odo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [odo_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              mismatches,
  output int                              waiting
);
  import odo_pkg::*;

  localparam logic [47:0] DIST_MAX = '1;

  // register copies
  logic [31:0] factor;
  logic [15:0] rpm_limit;
  logic [15:0] gap_limit;

  // integrator state
  logic [31:0] frac_mm;
  logic [47:0] total_dist;
  logic [47:0] trip_dist;
  logic [15:0] last_rpm;
  logic [31:0] last_time;
  logic        last_valid;
  logic [31:0] speed;
  logic [31:0] n_accepted;
  logic [31:0] n_bad_rpm;
  logic [31:0] n_gap;

  odo_out_t pending_results[$];
  int       results_seen;

  function automatic logic [47:0] add_capped(logic [47:0] a, logic [95:0] b);
    logic [96:0] s;
    s = {49'd0, a} + {1'b0, b};
    return (s > {49'd0, DIST_MAX}) ? DIST_MAX : s[47:0];
  endfunction

  // state update of one item, returns the result it should produce
  function automatic odo_out_t advance_odometer(odo_in_t it);
    odo_out_t     r;
    logic [2:0]   oc;
    logic [15:0]  rpm_cap;
    logic [31:0]  dt;
    logic [127:0] wide;
    logic [95:0]  whole_mm;
    rpm_cap = (rpm_limit == 16'd0) ? DEFAULT_MAX_RPM : rpm_limit;
    case (it.operation)
      OP_SAMPLE: begin
        if (factor == 32'd0) begin
          oc = OC_UNCAL;
        end else if (it.motor_rpm > rpm_cap) begin
          n_bad_rpm  = n_bad_rpm + 32'd1;
          last_time  = it.sample_time_ms;
          last_valid = 1'b0;
          oc = OC_BAD_RPM;
        end else begin
          wide  = 128'(it.motor_rpm);
          wide  = wide * 128'(factor);
          wide  = wide * 128'(SPEED_SCALE);
          speed = wide[63:32];
          dt = it.sample_time_ms - last_time;
          if (!last_valid) begin
            last_rpm   = it.motor_rpm;
            last_time  = it.sample_time_ms;
            last_valid = 1'b1;
            oc = OC_FIRST;
          end else if (dt == 32'd0) begin
            last_rpm = it.motor_rpm;
            oc = OC_DUPLICATE;
          end else if (dt > {16'd0, gap_limit}) begin
            n_gap     = n_gap + 32'd1;
            last_rpm  = it.motor_rpm;
            last_time = it.sample_time_ms;
            oc = OC_GAP;
          end else begin
            // trapezoid: (sum of rpm) x dt x factor / 2, carried in q32 mm
            wide = 128'(last_rpm);
            wide = wide + 128'(it.motor_rpm);
            wide = wide * 128'(dt);
            wide = wide * 128'(factor);
            wide = (wide >> 1) + 128'(frac_mm);
            frac_mm    = wide[31:0];
            whole_mm   = wide[127:32];
            total_dist = add_capped(total_dist, whole_mm);
            trip_dist  = add_capped(trip_dist, whole_mm);
            last_rpm   = it.motor_rpm;
            last_time  = it.sample_time_ms;
            n_accepted = n_accepted + 32'd1;
            oc = OC_ACCEPTED;
          end
        end
      end
      OP_CLEAR_TRIP: begin
        if (factor == 32'd0) begin
          oc = OC_UNCAL;
        end else begin
          trip_dist = '0;
          oc = OC_TRIP_CLR;
        end
      end
      OP_LOAD: begin
        total_dist = it.load_total_mm;
        trip_dist  = it.load_trip_mm;
        oc = OC_LOADED;
      end
      default: oc = OC_UNCAL;
    endcase
    r.outcome            = oc;
    r.total_mm           = total_dist;
    r.trip_mm            = trip_dist;
    r.speed_mm_per_s     = speed;
    r.accepted_count     = n_accepted;
    r.rejected_rpm_count = n_bad_rpm;
    r.gap_count          = n_gap;
    r.previous_rpm       = last_rpm;
    return r;
  endfunction

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("  %s expected %0d got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    odo_out_t want;
    if (!rst_n) begin
      factor     = '0;
      rpm_limit  = DEFAULT_MAX_RPM;
      gap_limit  = DEFAULT_MAX_GAP;
      frac_mm    = '0;
      total_dist = '0;
      trip_dist  = '0;
      last_rpm   = '0;
      last_time  = '0;
      last_valid = 1'b0;
      speed      = '0;
      n_accepted = '0;
      n_bad_rpm  = '0;
      n_gap      = '0;
      pending_results.delete();
    end else begin
      // results first: a result always belongs to an earlier transfer
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result %0d at %0t", results_seen, $time);
          end
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_data !== want) begin
            if (mismatches < 10) begin
              $display("mismatch on result %0d at %0t", results_seen, $time);
              report_field("outcome", want.outcome, out_data.outcome);
              report_field("total_mm", want.total_mm, out_data.total_mm);
              report_field("trip_mm", want.trip_mm, out_data.trip_mm);
              report_field("speed_mm_per_s", want.speed_mm_per_s, out_data.speed_mm_per_s);
              report_field("accepted_count", want.accepted_count, out_data.accepted_count);
              report_field("rejected_rpm_count", want.rejected_rpm_count,
                           out_data.rejected_rpm_count);
              report_field("gap_count", want.gap_count, out_data.gap_count);
              report_field("previous_rpm", want.previous_rpm, out_data.previous_rpm);
            end
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FACTOR: begin
            factor     = cfg_wdata;
            frac_mm    = '0;
            last_valid = 1'b0;
          end
          CFG_MAX_RPM: rpm_limit = cfg_wdata[15:0];
          CFG_MAX_GAP: gap_limit = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(advance_odometer(in_data));
      end
    end
    waiting = pending_results.size();
  end

endmodule

/* sim/tb_top.sv */
// tb_top: stimulus and verdict for the trapezoid odometer integrator
// depends on odo_pkg, trapezoid_odometer_integrator and odo_result_checker
`timescale 1ns / 100ps

module tb_top;
  import odo_pkg::*;

  // operation code the block does not define
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [47:0] DIST_MAX    = '1;
  // cycles with no transfer on either channel before the run is declared hung
  localparam int          QUIET_LIMIT = 5000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  odo_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  odo_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int fail_count;
  int results_due;

  // stimulus shaping: copies of the limits in force and the running timestamp
  logic [15:0] lim_rpm    = DEFAULT_MAX_RPM;
  logic [15:0] lim_gap    = DEFAULT_MAX_GAP;
  logic [31:0] now_ms     = '0;
  int          burst_left = 0;

  // receiver pattern state and watchdog
  int stall_mode   = 0;
  int mode_left    = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  trapezoid_odometer_integrator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  odo_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (fail_count),
    .waiting    (results_due)
  );

  // receiver: switches between always ready, coin-toss and mostly stalled,
  // each held for a random stretch of cycles
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // watchdog: a long stretch with no transfer at all means the block is hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic odo_in_t item_of(logic [1:0] op, logic [15:0] rpm, logic [31:0] t,
                                      logic [47:0] tot, logic [47:0] trp);
    odo_in_t it;
    it.operation      = op;
    it.motor_rpm      = rpm;
    it.sample_time_ms = t;
    it.load_total_mm  = tot;
    it.load_trip_mm   = trp;
    return it;
  endfunction

  // one transfer on the item channel; bursts of random length with random
  // pauses between them, some bursts back to back with no pause at all
  task automatic offer(input odo_in_t it);
    int pause;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (pause != 0) begin
        in_valid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every result is back, sampled away from the
  // rising edge so the count is stable
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    @(posedge clk);
  endtask

  // writes all three registers on consecutive edges, enable held throughout
  task automatic set_limits(input logic [31:0] f, input logic [15:0] r, input logic [15:0] g);
    lim_rpm = r;
    lim_gap = g;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FACTOR;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_index <= CFG_MAX_RPM;
    cfg_wdata <= {16'd0, r};
    @(posedge clk);
    cfg_index <= CFG_MAX_GAP;
    cfg_wdata <= {16'd0, g};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly plausible samples a short step after the last one, so that long
  // runs get integrated; the rest are repeats, overlong steps, implausible
  // rpm, clock jumps, trip clears, loads and plain noise
  task automatic make_random(output odo_in_t it);
    int          pick;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [15:0] eff;
    logic [31:0] span;
    pick = $urandom_range(0, 99);
    eff  = (lim_rpm == 16'd0) ? DEFAULT_MAX_RPM : lim_rpm;
    span = (lim_gap == 16'd0) ? 32'd1 : {16'd0, lim_gap};
    w0   = {$urandom, $urandom};
    w1   = {$urandom, $urandom};
    it.operation      = OP_SAMPLE;
    it.motor_rpm      = 16'($urandom_range(0, eff));
    it.sample_time_ms = now_ms + (($urandom_range(0, 3) == 0) ? $urandom_range(1, span)
                                  : $urandom_range(1, (span < 200) ? span : 200));
    // load fields carry junk on every item, the block must ignore them on all but loads
    it.load_total_mm  = w0[47:0];
    it.load_trip_mm   = w1[47:0];
    if (pick < 6) begin
      it.sample_time_ms = now_ms;
    end else if (pick < 11) begin
      it.sample_time_ms = now_ms + span + $urandom_range(1, 70000);
    end else if (pick < 16) begin
      if (eff != 16'hFFFF) it.motor_rpm = 16'($urandom_range(eff + 1, 16'hFFFF));
    end else if (pick < 19) begin
      it.sample_time_ms = $urandom;
    end else if (pick < 23) begin
      it.operation = OP_CLEAR_TRIP;
    end else if (pick < 26) begin
      it.operation = OP_LOAD;
      // half the loads sit just under the ceiling so later samples saturate
      if ($urandom_range(0, 1)) it.load_total_mm = DIST_MAX - $urandom_range(0, 100000);
      if ($urandom_range(0, 1)) it.load_trip_mm = DIST_MAX - $urandom_range(0, 100000);
    end else if (pick < 28) begin
      it.operation      = OP_UNUSED;
      it.motor_rpm      = 16'($urandom);
      it.sample_time_ms = $urandom;
    end else if (pick < 31) begin
      it.operation      = 2'($urandom_range(0, 3));
      it.motor_rpm      = 16'($urandom);
      it.sample_time_ms = $urandom;
    end
    if (it.operation == OP_SAMPLE) now_ms = it.sample_time_ms;
  endtask

  initial begin
    odo_in_t it;
    int      p;
    int      n;
    int      len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // straight out of reset the block is uncalibrated: only loads act
    offer(item_of(OP_SAMPLE, 16'd100, 32'd5, '0, '0));
    offer(item_of(OP_CLEAR_TRIP, 16'd0, 32'd0, '0, '0));
    offer(item_of(OP_LOAD, 16'hFFFF, 32'hFFFF_FFFF, DIST_MAX, DIST_MAX));
    offer(item_of(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, DIST_MAX, DIST_MAX));
    offer(item_of(OP_LOAD, 16'd0, 32'd0, '0, '0));

    // calibrated, rpm limit of zero standing for the default
    settle();
    set_limits(32'h0800_0000, 16'd0, 16'd10000);
    offer(item_of(OP_SAMPLE, 16'd0, 32'd0, '0, '0));          // first sample
    offer(item_of(OP_SAMPLE, 16'd12000, 32'd100, '0, '0));    // at the limit
    offer(item_of(OP_SAMPLE, 16'd12001, 32'd200, '0, '0));    // just over
    offer(item_of(OP_SAMPLE, 16'd5000, 32'd300, '0, '0));     // resync
    offer(item_of(OP_SAMPLE, 16'd7000, 32'd300, '0, '0));     // repeated timestamp
    offer(item_of(OP_SAMPLE, 16'd6000, 32'd10301, '0, '0));   // one ms too long
    offer(item_of(OP_SAMPLE, 16'd6000, 32'd20301, '0, '0));   // step exactly at the limit
    offer(item_of(OP_SAMPLE, 16'hFFFF, 32'd20400, '0, '0));   // top rpm rejected
    offer(item_of(OP_SAMPLE, 16'd3000, 32'hFFFF_FFF0, '0, '0));
    offer(item_of(OP_SAMPLE, 16'd3000, 32'h0000_0010, '0, '0)); // timestamp wraps
    offer(item_of(OP_LOAD, 16'd0, 32'd0, DIST_MAX - 48'd10, DIST_MAX - 48'd20));
    offer(item_of(OP_SAMPLE, 16'd12000, 32'h0000_1000, '0, '0)); // both distances saturate
    offer(item_of(OP_CLEAR_TRIP, 16'd0, 32'd0, '0, '0));
    offer(item_of(OP_UNUSED, 16'd0, 32'd0, '0, '0));

    // largest factor, gap limit of zero: every nonzero step is a gap
    settle();
    set_limits(32'hFFFF_FFFF, 16'hFFFF, 16'd0);
    offer(item_of(OP_SAMPLE, 16'hFFFF, 32'd1000, '0, '0));
    offer(item_of(OP_SAMPLE, 16'hFFFF, 32'd1000, '0, '0));
    offer(item_of(OP_SAMPLE, 16'hFFFF, 32'd1001, '0, '0));

    // largest factor, rpm sum and step together: the widest product
    settle();
    set_limits(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    offer(item_of(OP_SAMPLE, 16'hFFFF, 32'd7, '0, '0));
    offer(item_of(OP_SAMPLE, 16'hFFFF, 32'd65542, '0, '0));

    // random phases, each under its own register setting
    for (p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin set_limits($urandom, 16'd12000, 16'd10000); len = 260; end
        1: begin set_limits(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF); len = 220; end
        2: begin set_limits(32'd1, 16'd0, 16'd1); len = 200; end
        3: begin
          set_limits(32'd0, 16'($urandom), 16'($urandom_range(1, 65535)));
          len = 30;
        end
        4: begin
          set_limits($urandom_range(1, 32'h00FF_FFFF), 16'($urandom),
                     16'($urandom_range(1, 65535)));
          len = 220;
        end
        5: begin set_limits($urandom, 16'($urandom_range(1, 100)), 16'd0); len = 100; end
        6: begin set_limits($urandom, 16'd12000, 16'd1000); len = 250; end
        default: begin
          set_limits($urandom, 16'($urandom_range(1000, 65535)),
                     16'($urandom_range(1, 65535)));
          len = 245;
        end
      endcase
      for (n = 0; n < len; n++) begin
        make_random(it);
        offer(it);
      end
    end

    // drain, then a margin well beyond the longest item latency
    settle();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/odo_pkg.sv
sv/odo_mul.sv
sv/trapezoid_odometer_integrator.sv
sim/odo_result_checker.sv
sim/tb_top.sv
